/* design/vector3_normalize_assert.svh */
// assertion macros for the vector normalise block
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define VN_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define VN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/vn_pkg.sv */
// shared widths for the vector normalise pipeline
`default_nettype none
package vn_pkg;
    localparam int VN_COMP_W = 32;
    localparam int VN_SUM_W  = 64;
    localparam int VN_QUO_W  = 61;
    localparam int VN_ROOT_W = 32;
endpackage
`default_nettype wire

/* design/vn_div_cell.sv */
// one restoring division step: one quotient bit per cell
`default_nettype none
module vn_div_cell
    import vn_pkg::*;
#(
    parameter int DIV_W = VN_SUM_W,
    parameter int QUO_W = VN_QUO_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DIV_W-1:0] i_div,
    input  wire logic [DIV_W-1:0] i_rem,
    input  wire logic             i_bit,
    input  wire logic [QUO_W-1:0] i_quo,
    output logic      [DIV_W-1:0] o_rem,
    output logic      [QUO_W-1:0] o_quo
);
    logic [DIV_W:0]   w_sh;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;

    always_comb begin
        w_sh   = {i_rem, i_bit};
        w_diff = w_sh - {1'b0, i_div};
        w_ge   = (w_sh >= {1'b0, i_div});
        n_rem  = w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
        n_quo  = {i_quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule
`default_nettype wire

/* design/vn_sqrt_cell.sv */
// one digit-by-digit square root step: one root bit per cell
`default_nettype none
module vn_sqrt_cell
    import vn_pkg::*;
#(
    parameter int ROOT_W = VN_ROOT_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [2*ROOT_W-1:0] i_rad,
    input  wire logic [ROOT_W+1:0]   i_rem,
    input  wire logic [ROOT_W-1:0]   i_root,
    output logic      [2*ROOT_W-1:0] o_rad,
    output logic      [ROOT_W+1:0]   o_rem,
    output logic      [ROOT_W-1:0]   o_root
);
    logic [ROOT_W+1:0]   w_sh;
    logic [ROOT_W+1:0]   w_trial;
    logic                w_ge;
    logic [2*ROOT_W-1:0] r_rad, n_rad;
    logic [ROOT_W+1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;

    always_comb begin
        // remainder stays below 2^ROOT_W before the shift
        w_sh    = {i_rem[ROOT_W-1:0], i_rad[2*ROOT_W-1:2*ROOT_W-2]};
        w_trial = {i_root, 2'b01};
        w_ge    = (w_sh >= w_trial);
        n_rem   = w_ge ? (w_sh - w_trial) : w_sh;
        n_root  = {i_root[ROOT_W-2:0], w_ge};
        n_rad   = {i_rad[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

/* design/vector3_normalize.sv */
// top level: 3d vector length and unit vector, fixed point, fully pipelined
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_stall  | i_vec_x, i_vec_y, i_vec_z
//  output  | out       | o_valid / i_stall  | o_unit_x/y/z, o_length, o_zero_vector
//
// one beat accepted per cycle when the output side is not stalled
// the pipeline is 3 front stages (abs, square, sum), 61 division cells,
// 32 square root cells and the output register
// the whole row of cells advances together; a stalled output beat freezes it
// reset is synchronous, active low, and clears only the valid chain
`default_nettype none
`include "vector3_normalize_assert.svh"
module vector3_normalize
    import vn_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic signed [VN_COMP_W-1:0] i_vec_x,
    input  wire logic signed [VN_COMP_W-1:0] i_vec_y,
    input  wire logic signed [VN_COMP_W-1:0] i_vec_z,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [VN_COMP_W-1:0]      o_unit_x,
    output logic signed [VN_COMP_W-1:0]      o_unit_y,
    output logic signed [VN_COMP_W-1:0]      o_unit_z,
    output logic        [VN_COMP_W-1:0]      o_length,
    output logic                             o_zero_vector
);
    localparam int PRE_N   = 3;
    localparam int OUT_IDX = PRE_N + VN_QUO_W + VN_ROOT_W;
    localparam int LANES   = 3;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } t_flags;

    // valid and sign/zero flags travel alongside the data
    logic   r_vld [0:OUT_IDX];
    t_flags r_flg [0:OUT_IDX];

    // global advance: every cell moves unless a finished beat is held
    logic w_adv;
    assign o_stall = r_vld[OUT_IDX] & i_stall;
    assign w_adv   = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= OUT_IDX; k++) r_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= OUT_IDX; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_flg[0].neg  <= {i_vec_z[VN_COMP_W-1], i_vec_y[VN_COMP_W-1],
                              i_vec_x[VN_COMP_W-1]};
            r_flg[0].zero <= (i_vec_x == '0) && (i_vec_y == '0) && (i_vec_z == '0);
            for (int k = 1; k <= OUT_IDX; k++) r_flg[k] <= r_flg[k-1];
        end
    end

    // front: magnitudes, squares, sum of squares
    logic [VN_COMP_W-1:0] r_abs  [0:LANES-1];
    logic [VN_SUM_W-1:0]  r_sqb  [0:LANES-1];
    logic [VN_SUM_W-1:0]  r_sqc  [0:LANES-1];
    logic [VN_SUM_W-1:0]  r_dsum [0:VN_QUO_W];
    logic [VN_COMP_W-1:0] w_in   [0:LANES-1];

    assign w_in[0] = i_vec_x;
    assign w_in[1] = i_vec_y;
    assign w_in[2] = i_vec_z;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < LANES; l++) begin
                // most negative value maps onto 2^31, still fits unsigned
                r_abs[l] <= w_in[l][VN_COMP_W-1] ? (~w_in[l] + 1'b1) : w_in[l];
                r_sqb[l] <= VN_SUM_W'(r_abs[l]) * VN_SUM_W'(r_abs[l]);
                r_sqc[l] <= r_sqb[l];
            end
            // sum at most 3 * 2^62, no overflow of 64 bits
            r_dsum[0] <= r_sqb[0] + r_sqb[1] + r_sqb[2];
        end
    end

    // divisor travels down the row next to the division cells
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < VN_QUO_W; j++) r_dsum[j+1] <= r_dsum[j];
        end
    end

    // division lanes: q = floor(sq * 2^60 / sum)
    logic [VN_QUO_W-1:0] w_quo_out [0:LANES-1];

    for (genvar l = 0; l < LANES; l++) begin : g_div
        logic [VN_SUM_W-1:0] w_rem [0:VN_QUO_W];
        logic [VN_QUO_W-1:0] w_quo [0:VN_QUO_W];

        // the first cell shifts in the low bit of the square itself
        assign w_rem[0] = {1'b0, r_sqc[l][VN_SUM_W-1:1]};
        assign w_quo[0] = '0;

        for (genvar j = 0; j < VN_QUO_W; j++) begin : g_cell
            vn_div_cell #(
                .DIV_W (VN_SUM_W),
                .QUO_W (VN_QUO_W)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_div (r_dsum[j]),
                .i_rem (w_rem[j]),
                .i_bit ((j == 0) ? r_sqc[l][0] : 1'b0),
                .i_quo (w_quo[j]),
                .o_rem (w_rem[j+1]),
                .o_quo (w_quo[j+1])
            );
        end

        assign w_quo_out[l] = w_quo[VN_QUO_W];
    end

    // root lanes: three unit components and the length
    logic [VN_SUM_W-1:0]  w_rad_in   [0:LANES];
    logic [VN_ROOT_W-1:0] w_root_out [0:LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_rad
        assign w_rad_in[l] = {{(VN_SUM_W-VN_QUO_W){1'b0}}, w_quo_out[l]};
    end
    assign w_rad_in[LANES] = r_dsum[VN_QUO_W];

    for (genvar l = 0; l <= LANES; l++) begin : g_sqrt
        logic [2*VN_ROOT_W-1:0] w_rad  [0:VN_ROOT_W];
        logic [VN_ROOT_W+1:0]   w_rem  [0:VN_ROOT_W];
        logic [VN_ROOT_W-1:0]   w_root [0:VN_ROOT_W];

        assign w_rad[0]  = w_rad_in[l];
        assign w_rem[0]  = '0;
        assign w_root[0] = '0;

        for (genvar k = 0; k < VN_ROOT_W; k++) begin : g_cell
            vn_sqrt_cell #(
                .ROOT_W (VN_ROOT_W)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_rad  (w_rad[k]),
                .i_rem  (w_rem[k]),
                .i_root (w_root[k]),
                .o_rad  (w_rad[k+1]),
                .o_rem  (w_rem[k+1]),
                .o_root (w_root[k+1])
            );
        end

        assign w_root_out[l] = w_root[VN_ROOT_W];
    end

    // output register: restore signs, force zero vector results
    logic [VN_COMP_W-1:0] r_unit [0:LANES-1];
    logic [VN_COMP_W-1:0] r_length;
    logic                 r_zero;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < LANES; l++) begin
                if (r_flg[OUT_IDX-1].zero) begin
                    r_unit[l] <= '0;
                end else if (r_flg[OUT_IDX-1].neg[l]) begin
                    r_unit[l] <= VN_COMP_W'(~w_root_out[l] + 1'b1);
                end else begin
                    r_unit[l] <= VN_COMP_W'(w_root_out[l]);
                end
            end
            r_length <= r_flg[OUT_IDX-1].zero ? '0 : VN_COMP_W'(w_root_out[LANES]);
            r_zero   <= r_flg[OUT_IDX-1].zero;
        end
    end

    assign o_valid       = r_vld[OUT_IDX];
    assign o_unit_x      = r_unit[0];
    assign o_unit_y      = r_unit[1];
    assign o_unit_z      = r_unit[2];
    assign o_length      = r_length;
    assign o_zero_vector = r_zero;

    // zero vector beats carry all-zero payload
    `VN_ASSERT_SAME(a_zero_payload, i_clk, i_rst_n, o_valid && o_zero_vector, (o_length == '0) && (o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0), "zero vector beat with nonzero payload")
    // any nonzero vector has length of at least one lsb
    `VN_ASSERT_SAME(a_len_nonzero, i_clk, i_rst_n, o_valid && !o_zero_vector, o_length != '0, "nonzero vector with zero length")
    // unit components never exceed one in magnitude
    `VN_ASSERT_SAME(a_unit_range, i_clk, i_rst_n, o_valid, (o_unit_x <= 32'sh4000_0000) && (o_unit_x >= -32'sh4000_0000) && (o_unit_y <= 32'sh4000_0000) && (o_unit_y >= -32'sh4000_0000) && (o_unit_z <= 32'sh4000_0000) && (o_unit_z >= -32'sh4000_0000), "unit component out of range")
    // an accepted beat enters the first stage
    `VN_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0], "accepted beat lost at entry")
endmodule
`default_nettype wire
